// ----- design/bel_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bully election node package
// Shared item types, message and role codes, and register indexes.
// ----------------------------------------------------------------------------
package bel_pkg;

    localparam int CLOCK_W     = 31;
    localparam int RANK_W      = 4;
    localparam int BURST_W     = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};
    localparam logic [BURST_W-1:0] MAX_BURST = 5'd16;

    // Operation codes of an input item.
    localparam logic [2:0] MSG_ELECTION = 3'd0;
    localparam logic [2:0] MSG_PROBE    = 3'd1;
    localparam logic [2:0] MSG_ALIVE    = 3'd2;
    localparam logic [2:0] MSG_COORD    = 3'd3;
    localparam logic [2:0] MSG_ANSWER   = 3'd4;
    localparam logic [2:0] OP_TICK      = 3'd5;
    localparam logic [2:0] OP_START     = 3'd6;

    localparam logic [1:0] ROLE_PROBING      = 2'd0;
    localparam logic [1:0] ROLE_ELECTING     = 2'd1;
    localparam logic [1:0] ROLE_COORDINATING = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_MY_RANK         = 3'd0;
    localparam logic [2:0] REG_NODE_COUNT      = 3'd1;
    localparam logic [2:0] REG_TIMEOUT_TICKS   = 3'd2;
    localparam logic [2:0] REG_PROBE_INTERVAL  = 3'd3;
    localparam logic [2:0] REG_FAILURE_PERCENT = 3'd4;
    localparam logic [2:0] REG_REVIVE_TICKS    = 3'd5;

    typedef struct packed {
        logic [2:0]         operation;
        logic [RANK_W-1:0]  source_rank;
        logic [CLOCK_W-1:0] remote_clock;
        logic [6:0]         survival_roll;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         message_kind;
        logic [RANK_W-1:0]  destination;
        logic [CLOCK_W-1:0] clock_stamp;
        logic [1:0]         node_role;
        logic               last;
    } out_item_t;

    // Emission plan of one transaction: an optional single message, then an
    // ascending election sweep, then a descending coordinator sweep.
    typedef struct packed {
        logic               single_v;
        logic [2:0]         single_kind;
        logic [RANK_W-1:0]  single_dest;
        logic               elect_v;
        logic [RANK_W-1:0]  elect_lo;
        logic [RANK_W-1:0]  elect_hi;
        logic               coord_v;
        logic [RANK_W-1:0]  coord_hi;
        logic [BURST_W-1:0] total;
        logic [CLOCK_W-1:0] base_clock;
        logic [1:0]         role;
    } plan_t;

endpackage

// ----- design/bel_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bully election node front end
// Holds the configuration and node state, takes one input transaction per
// cycle while the queue is not full, updates the state and queues its plan of messages.
// ----------------------------------------------------------------------------
module bel_front
    import bel_pkg::*;
#(
    parameter int NODES      = 16,
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  in_item_t    item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        queue_full,
    output logic        plan_push,
    output plan_t       plan
);

    localparam int NODE_CAP = (NODES < 16) ? NODES : 16;
    localparam int CMP_W    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [RANK_W-1:0] LEADER_RESET = RANK_W'(NODE_CAP - 1);
    localparam logic [1:0] ROLE_RESET =
        (NODE_CAP - 1 == 1) ? ROLE_COORDINATING : ROLE_PROBING;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [3:0]  my_rank_reg;
    logic [4:0]  node_count_reg;
    logic [15:0] timeout_ticks_reg;
    logic [15:0] probe_interval_reg;
    logic [6:0]  failure_percent_reg;
    logic [15:0] revive_ticks_reg;

    logic [1:0]            role_reg, role_next;
    logic                  alive_reg, alive_next;
    logic                  answered_reg, answered_next;
    logic [COUNT_BITS-1:0] tcount_reg, tcount_next;
    logic [COUNT_BITS-1:0] pcount_reg, pcount_next;
    logic [RANK_W-1:0]     leader_reg, leader_next;
    logic [CLOCK_W-1:0]    clock_reg, clock_next;

    logic               accept;
    logic [4:0]         rank_lim;
    logic [RANK_W-1:0]  top_rank;
    logic [CLOCK_W-1:0] base_clock;
    logic               single_v;
    logic [2:0]         single_kind;
    logic [RANK_W-1:0]  single_dest;
    logic               elect_req;
    logic               coord_req;
    logic               elect_v;
    logic               coord_v;
    logic [4:0]         rank_plus;
    logic [4:0]         elect_cnt;
    logic [4:0]         coord_cnt;
    logic [5:0]         burst_sum;
    logic [BURST_W-1:0] total;
    logic [CLOCK_W:0]   clock_sum;

    assign accept = push && !queue_full;

    assign rank_lim = (node_count_reg > 5'(NODE_CAP)) ? 5'(NODE_CAP) : node_count_reg;
    assign top_rank = (rank_lim == 5'd0) ? '0 : RANK_W'(rank_lim - 5'd1);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_rank_reg         <= 4'd1;
            node_count_reg      <= 5'd16;
            timeout_ticks_reg   <= 16'd5;
            probe_interval_reg  <= 16'd2;
            failure_percent_reg <= 7'd0;
            revive_ticks_reg    <= 16'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MY_RANK:         my_rank_reg         <= cfg_data[3:0];
                REG_NODE_COUNT:      node_count_reg      <= cfg_data[4:0];
                REG_TIMEOUT_TICKS:   timeout_ticks_reg   <= cfg_data;
                REG_PROBE_INTERVAL:  probe_interval_reg  <= cfg_data;
                REG_FAILURE_PERCENT: failure_percent_reg <= cfg_data[6:0];
                REG_REVIVE_TICKS:    revive_ticks_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Message handling and threshold checks, in the order the protocol
    // applies them within one transaction.
    always_comb
    begin
        role_next     = role_reg;
        alive_next    = alive_reg;
        answered_next = answered_reg;
        tcount_next   = tcount_reg;
        pcount_next   = pcount_reg;
        leader_next   = leader_reg;
        base_clock    = clock_reg;
        single_v      = 1'b0;
        single_kind   = MSG_PROBE;
        single_dest   = '0;
        elect_req     = 1'b0;
        coord_req     = 1'b0;

        if (item.operation == OP_START)
        begin
            leader_next   = top_rank;
            alive_next    = 1'b1;
            answered_next = 1'b0;
            tcount_next   = '0;
            pcount_next   = '0;
            if (my_rank_reg == top_rank)
            begin
                role_next = ROLE_COORDINATING;
                coord_req = 1'b1;
            end
            else
            begin
                role_next = ROLE_PROBING;
            end
        end
        else if (item.operation <= OP_TICK)
        begin
            if (item.operation != OP_TICK && clock_reg < item.remote_clock)
            begin
                base_clock = item.remote_clock;
            end
            if (alive_reg)
            begin
                unique case (item.operation)
                    MSG_ELECTION:
                    begin
                        if (my_rank_reg > item.source_rank)
                        begin
                            single_v    = 1'b1;
                            single_kind = MSG_ANSWER;
                            single_dest = item.source_rank;
                            if (role_reg == ROLE_PROBING)
                            begin
                                role_next     = ROLE_ELECTING;
                                answered_next = 1'b0;
                                tcount_next   = '0;
                                pcount_next   = '0;
                                elect_req     = 1'b1;
                            end
                        end
                    end
                    MSG_PROBE:
                    begin
                        if (role_reg == ROLE_COORDINATING)
                        begin
                            if (item.survival_roll > failure_percent_reg)
                            begin
                                single_v    = 1'b1;
                                single_kind = MSG_ALIVE;
                                single_dest = item.source_rank;
                            end
                            else
                            begin
                                alive_next    = 1'b0;
                                role_next     = ROLE_PROBING;
                                answered_next = 1'b0;
                                tcount_next   = '0;
                                pcount_next   = '0;
                            end
                        end
                    end
                    MSG_ALIVE:
                    begin
                        if (role_reg == ROLE_PROBING)
                        begin
                            tcount_next = '0;
                        end
                    end
                    MSG_COORD:
                    begin
                        if (my_rank_reg > item.source_rank)
                        begin
                            role_next = ROLE_ELECTING;
                            elect_req = 1'b1;
                        end
                        else
                        begin
                            leader_next = item.source_rank;
                            role_next   = ROLE_PROBING;
                        end
                        answered_next = 1'b0;
                        tcount_next   = '0;
                        pcount_next   = '0;
                    end
                    MSG_ANSWER:
                    begin
                        role_next     = ROLE_ELECTING;
                        answered_next = 1'b1;
                        tcount_next   = '0;
                        pcount_next   = '0;
                    end
                    OP_TICK:
                    begin
                        if (role_reg == ROLE_PROBING && pcount_reg != CNT_MAX)
                        begin
                            pcount_next = pcount_reg + 1'b1;
                        end
                        if (tcount_reg != CNT_MAX)
                        begin
                            tcount_next = tcount_reg + 1'b1;
                        end
                    end
                    default: ;
                endcase

                // A node that has just died skips the threshold checks.
                if (alive_next)
                begin
                    if (role_next == ROLE_PROBING)
                    begin
                        if (CMP_W'(pcount_next) >= CMP_W'(probe_interval_reg))
                        begin
                            single_v    = 1'b1;
                            single_kind = MSG_PROBE;
                            single_dest = leader_next;
                            pcount_next = '0;
                        end
                        if (CMP_W'(tcount_next) >= CMP_W'(timeout_ticks_reg))
                        begin
                            role_next     = ROLE_ELECTING;
                            answered_next = 1'b0;
                            tcount_next   = '0;
                            pcount_next   = '0;
                            elect_req     = 1'b1;
                        end
                    end
                    else if (role_next == ROLE_ELECTING)
                    begin
                        if (CMP_W'(tcount_next) >= CMP_W'(timeout_ticks_reg))
                        begin
                            if (!answered_next)
                            begin
                                leader_next = my_rank_reg;
                                role_next   = ROLE_COORDINATING;
                                coord_req   = 1'b1;
                            end
                            else
                            begin
                                role_next = ROLE_ELECTING;
                                elect_req = 1'b1;
                            end
                            answered_next = 1'b0;
                            tcount_next   = '0;
                            pcount_next   = '0;
                        end
                    end
                end
            end
            else
            begin
                if (item.operation == OP_TICK && tcount_reg != CNT_MAX)
                begin
                    tcount_next = tcount_reg + 1'b1;
                end
                if (CMP_W'(tcount_next) >= CMP_W'(revive_ticks_reg))
                begin
                    alive_next    = 1'b1;
                    role_next     = ROLE_ELECTING;
                    answered_next = 1'b0;
                    tcount_next   = '0;
                    pcount_next   = '0;
                    elect_req     = 1'b1;
                end
            end
        end
    end

    // Burst length, capped, and the clock after all stamps of the burst.
    assign rank_plus = {1'b0, my_rank_reg} + 5'd1;
    assign elect_cnt = (rank_lim > rank_plus) ? (rank_lim - rank_plus) : 5'd0;
    assign coord_cnt = (my_rank_reg > 4'd1) ? ({1'b0, my_rank_reg} - 5'd1) : 5'd0;
    assign elect_v   = elect_req && (elect_cnt != 5'd0);
    assign coord_v   = coord_req && (coord_cnt != 5'd0);
    assign burst_sum = 6'(single_v) + (elect_v ? {1'b0, elect_cnt} : 6'd0)
                     + (coord_v ? {1'b0, coord_cnt} : 6'd0);
    assign total     = (burst_sum > 6'(MAX_BURST)) ? MAX_BURST : burst_sum[BURST_W-1:0];
    assign clock_sum = {1'b0, base_clock} + (CLOCK_W + 1)'(total);
    assign clock_next = clock_sum[CLOCK_W] ? CLOCK_MAX : clock_sum[CLOCK_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg     <= ROLE_RESET;
            alive_reg    <= 1'b1;
            answered_reg <= 1'b0;
            tcount_reg   <= '0;
            pcount_reg   <= '0;
            leader_reg   <= LEADER_RESET;
            clock_reg    <= '0;
        end
        else if (accept)
        begin
            role_reg     <= role_next;
            alive_reg    <= alive_next;
            answered_reg <= answered_next;
            tcount_reg   <= tcount_next;
            pcount_reg   <= pcount_next;
            leader_reg   <= leader_next;
            clock_reg    <= clock_next;
        end
    end

    assign plan_push = accept && (total != '0);

    always_comb
    begin
        plan.single_v    = single_v;
        plan.single_kind = single_kind;
        plan.single_dest = single_dest;
        plan.elect_v     = elect_v;
        plan.elect_lo    = rank_plus[RANK_W-1:0];
        plan.elect_hi    = RANK_W'(rank_lim - 5'd1);
        plan.coord_v     = coord_v;
        plan.coord_hi    = my_rank_reg - 4'd1;
        plan.total       = total;
        plan.base_clock  = base_clock;
        plan.role        = role_next;
    end

endmodule

// ----- design/bel_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bully election node plan queue
// Short first-word-fall-through queue between the front end and the sender.
// ----------------------------------------------------------------------------
module bel_fifo
    import bel_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  plan_t wr_data,
    output logic  full,
    input  logic  rd_en,
    output plan_t rd_data,
    output logic  empty
);

    plan_t                  slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic                   do_wr;
    logic                   do_rd;

    assign full    = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/bel_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bully election node sender
// Expands one queued plan into its messages, one per cycle while the one-entry
// result register is free or popped, stamping each with the next Lamport clock value.
// ----------------------------------------------------------------------------
module bel_back
    import bel_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  plan_t     plan,
    input  logic      plan_empty,
    output logic      plan_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    localparam logic [1:0] PH_SINGLE = 2'd0;
    localparam logic [1:0] PH_ELECT  = 2'd1;
    localparam logic [1:0] PH_COORD  = 2'd2;

    logic               busy_reg, busy_next;
    logic [1:0]         phase_reg, phase_next;
    logic [RANK_W-1:0]  rank_reg, rank_next;
    logic [BURST_W-1:0] sent_reg, sent_next;
    logic [CLOCK_W-1:0] stamp_reg, stamp_next;
    plan_t              work_reg;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg;

    logic               emit;
    logic               is_last;
    logic [CLOCK_W-1:0] stamp_inc;
    logic [2:0]         kind;
    logic [RANK_W-1:0]  dest;

    assign plan_pop  = !busy_reg && !plan_empty;
    assign emit      = busy_reg && (!out_valid_reg || pop);
    assign is_last   = (sent_reg == work_reg.total - 1'b1);
    assign stamp_inc = (stamp_reg == CLOCK_MAX) ? CLOCK_MAX : stamp_reg + 1'b1;

    always_comb
    begin
        unique case (phase_reg)
            PH_SINGLE:
            begin
                kind = work_reg.single_kind;
                dest = work_reg.single_dest;
            end
            PH_ELECT:
            begin
                kind = MSG_ELECTION;
                dest = rank_reg;
            end
            PH_COORD:
            begin
                kind = MSG_COORD;
                dest = rank_reg;
            end
            default:
            begin
                kind = MSG_COORD;
                dest = rank_reg;
            end
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        rank_next      = rank_reg;
        sent_next      = sent_reg;
        stamp_next     = stamp_reg;
        out_valid_next = out_valid_reg;

        if (plan_pop)
        begin
            busy_next  = 1'b1;
            sent_next  = '0;
            stamp_next = plan.base_clock;
            if (plan.single_v)
            begin
                phase_next = PH_SINGLE;
            end
            else if (plan.elect_v)
            begin
                phase_next = PH_ELECT;
            end
            else
            begin
                phase_next = PH_COORD;
            end
            rank_next = plan.elect_v ? plan.elect_lo : plan.coord_hi;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            stamp_next     = stamp_inc;
            sent_next      = sent_reg + 1'b1;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                // The burst length already covers which segments exist, so
                // the sweeps only need to step to the following segment.
                unique case (phase_reg)
                    PH_SINGLE:
                    begin
                        if (work_reg.elect_v)
                        begin
                            phase_next = PH_ELECT;
                            rank_next  = work_reg.elect_lo;
                        end
                        else
                        begin
                            phase_next = PH_COORD;
                            rank_next  = work_reg.coord_hi;
                        end
                    end
                    PH_ELECT:
                    begin
                        if (rank_reg == work_reg.elect_hi)
                        begin
                            phase_next = PH_COORD;
                            rank_next  = work_reg.coord_hi;
                        end
                        else
                        begin
                            rank_next = rank_reg + 1'b1;
                        end
                    end
                    PH_COORD:
                    begin
                        rank_next = rank_reg - 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_COORD;
                    end
                endcase
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_SINGLE;
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg  <= rank_next;
        stamp_reg <= stamp_next;
        if (plan_pop)
        begin
            work_reg <= plan;
        end
        if (emit)
        begin
            out_reg.message_kind <= kind;
            out_reg.destination  <= dest;
            out_reg.clock_stamp  <= stamp_inc;
            out_reg.node_role    <= work_reg.role;
            out_reg.last         <= is_last;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

// ----- design/bully_election_node.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bully election node
// One node of a bully leader election with a Lamport clock.
// ----------------------------------------------------------------------------
// Input transactions (received messages, ticks and start) are taken one per
// cycle while full is low; the front end updates the node state at once and
// queues a plan of the messages to send in a four-entry queue. The sender
// drains that queue and delivers one message per cycle while results are
// taken, so a transaction that causes n messages (at most 16) occupies the
// sender to load its plan and then to send each message. Transactions that
// cause no message take no sender time. Configuration registers are written
// through cfg_we, cfg_index and cfg_data and take effect on the next transaction.
// ----------------------------------------------------------------------------
module bully_election_node
    import bel_pkg::*;
#(
    parameter int NODES      = 16,
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    item,
    output logic        empty,
    input  logic        pop,
    output out_item_t   result,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic  plan_push;
    plan_t plan_in;
    logic  plan_pop;
    plan_t plan_out;
    logic  plan_empty;

    bel_front #(
        .NODES      (NODES),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (full),
        .plan_push  (plan_push),
        .plan       (plan_in)
    );

    bel_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (plan_push),
        .wr_data (plan_in),
        .full    (full),
        .rd_en   (plan_pop),
        .rd_data (plan_out),
        .empty   (plan_empty)
    );

    bel_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan       (plan_out),
        .plan_empty (plan_empty),
        .plan_pop   (plan_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ----- design/bel_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bully election node checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module bel_assertions
    import bel_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input out_item_t result
);

    // A waiting result that is not taken stays unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed while waiting");

    // Only defined message kinds and roles are sent.
    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.message_kind <= MSG_ANSWER)
                && (result.node_role <= ROLE_COORDINATING))
        else $error("undefined message kind or role");

    // Within one burst the role is the same and the clock never goes back.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !result.last) ##1 !empty |->
            (result.node_role == $past(result.node_role))
            && (result.clock_stamp >= $past(result.clock_stamp)))
        else $error("burst role or clock stamp mismatch");

    // Nothing is offered in the first cycle after reset.
    a_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty)
        else $error("result offered right after reset");

endmodule

bind bully_election_node bel_assertions u_bel_assertions (.*);
